// ===== rtl/nbh_pkg.sv =====
// Shared types, constants and table functions of the nearest-neighbor energy block.
// Used by all RTL modules and the testbench; depends on nothing else.
`default_nettype none

package nbh_pkg;

    localparam int BASES_CARRIED = 23;
    localparam int BASE_W = 2;
    localparam int WINDOW_W = 46;
    localparam int SCRUNCH_W = 4;
    localparam int LAST_W = 5;
    localparam int CFG_W = 10;
    localparam int ACC_W = 16;
    localparam int OUT_W = 15;
    localparam int DNA_W = 9;
    localparam int RNA_W = 10;
    localparam int GROUP = 6;

    localparam logic [LAST_W-1:0] LAST_UNSCRUNCHED = 5'd13;
    localparam logic [LAST_W-1:0] LAST_OFFSET = 5'd12;
    localparam logic [LAST_W-1:0] START_UNSCRUNCHED = 5'd3;
    localparam logic [LAST_W-1:0] START_SCRUNCHED = 5'd11;
    localparam logic [ACC_W-1:0] SCRUNCH_STEP = 16'd100;

    localparam logic [CFG_W-1:0] INIT_GC_RESET = 10'd98;
    localparam logic [CFG_W-1:0] INIT_AT_RESET = 10'd103;
    localparam logic [CFG_W-1:0] HYBRID_INIT_RESET = 10'd310;

    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;

    localparam logic signed [ACC_W-1:0] SAT_HI = 16'sd16383;
    localparam logic signed [ACC_W-1:0] SAT_LO = -16'sd16384;

    typedef enum logic [1:0] {
        REG_INIT_GC      = 2'd0,
        REG_INIT_AT      = 2'd1,
        REG_HYBRID_INIT  = 2'd2,
        REG_SLIDING_MODE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [LAST_W-1:0] last;
        logic              s_zero;
        logic              s_one;
        logic              full_pre;
        logic              slide;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [DNA_W-1:0] bub;
        logic signed [DNA_W-1:0] post;
        logic signed [RNA_W-1:0] hyb;
        logic signed [RNA_W-1:0] tr;
    } lane_terms_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] bub_base;
        logic signed [ACC_W-1:0] post_base;
        logic [CFG_W-1:0]        hinit;
    } side_t;

    localparam logic signed [DNA_W-1:0] DNA_NN [16] = '{
        -9'sd100, -9'sd144, -9'sd128,  -9'sd88,
        -9'sd145, -9'sd184, -9'sd217, -9'sd128,
        -9'sd130, -9'sd224, -9'sd184, -9'sd144,
         -9'sd58, -9'sd130, -9'sd145, -9'sd100
    };

    localparam logic signed [RNA_W-1:0] RNA_NN [16] = '{
        -10'sd100, -10'sd210, -10'sd180,  -10'sd90,
         -10'sd90, -10'sd210, -10'sd170,  -10'sd90,
        -10'sd130, -10'sd270, -10'sd290, -10'sd110,
         -10'sd60, -10'sd150, -10'sd160,  -10'sd20
    };

    function automatic logic [CFG_W-1:0] end_pen(
        input logic [BASE_W-1:0] b,
        input logic [CFG_W-1:0]  gc,
        input logic [CFG_W-1:0]  at
    );
        return (b == BASE_C || b == BASE_G) ? gc : at;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nbh_lane.sv =====
// One lane: looks up the DNA/DNA and RNA/DNA stacking terms of one base pair position
// and masks them by the window geometry. Depends on nbh_pkg.
`default_nettype none

module nbh_lane
    import nbh_pkg::*;
#(
    parameter int LANE_POS = 1
)
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [3:0]  pair,
    input  wire lane_ctl_t   ctl,
    output lane_terms_t      terms
);

    localparam logic [LAST_W-1:0] POS = LAST_W'(LANE_POS);
    localparam logic [LAST_W-1:0] POS_NEXT = LAST_W'(LANE_POS + 1);

    lane_terms_t terms_reg;
    lane_terms_t terms_next;

    logic [LAST_W-1:0] start;
    logic              in_bub;
    logic              in_post;
    logic              in_hyb;
    logic              in_tr;

    always_comb
    begin
        start   = ctl.s_zero ? START_UNSCRUNCHED : START_SCRUNCHED;
        in_bub  = POS < ctl.last;
        in_post = (in_bub && (ctl.full_pre || LANE_POS >= 2)) || (POS == ctl.last);
        in_hyb  = !ctl.s_one && (POS >= start) && (POS_NEXT < ctl.last);
        in_tr   = in_hyb && (LANE_POS > 3 || !ctl.slide);

        terms_next.bub  = in_bub  ? DNA_NN[pair] : '0;
        terms_next.post = in_post ? DNA_NN[pair] : '0;
        terms_next.hyb  = in_hyb  ? RNA_NN[pair] : '0;
        terms_next.tr   = in_tr   ? RNA_NN[pair] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

`default_nettype wire

// ===== rtl/nbh_merge.sv =====
// Merging stage: a two-level registered adder tree over the lane terms, then the
// final combination and saturation of the three energies. Depends on nbh_pkg.
`default_nettype none

module nbh_merge
    import nbh_pkg::*;
#(
    parameter int NLANE = 21
)
(
    input  wire logic                     clk,
    input  wire logic                     en2,
    input  wire logic                     en3,
    input  wire lane_terms_t              terms [NLANE],
    input  wire side_t                    side,
    output logic signed [OUT_W-1:0]       total,
    output logic signed [OUT_W-1:0]       hybrid,
    output logic signed [OUT_W-1:0]       shifted
);

    localparam int NGRP = (NLANE + GROUP - 1) / GROUP;
    localparam int NPAD = NGRP * GROUP;

    lane_terms_t pad [NPAD];

    logic signed [ACC_W-1:0] bub_grp_reg  [NGRP];
    logic signed [ACC_W-1:0] post_grp_reg [NGRP];
    logic signed [ACC_W-1:0] hyb_grp_reg  [NGRP];
    logic signed [ACC_W-1:0] tr_grp_reg   [NGRP];
    logic signed [ACC_W-1:0] bub_grp_next  [NGRP];
    logic signed [ACC_W-1:0] post_grp_next [NGRP];
    logic signed [ACC_W-1:0] hyb_grp_next  [NGRP];
    logic signed [ACC_W-1:0] tr_grp_next   [NGRP];
    side_t                   side_reg;

    logic signed [OUT_W-1:0] total_reg;
    logic signed [OUT_W-1:0] hybrid_reg;
    logic signed [OUT_W-1:0] shifted_reg;
    logic signed [OUT_W-1:0] total_next;
    logic signed [OUT_W-1:0] hybrid_next;
    logic signed [OUT_W-1:0] shifted_next;

    genvar j;
    generate
        for (j = 0; j < NPAD; j++)
        begin : g_pad
            if (j < NLANE)
            begin : g_used
                assign pad[j] = terms[j];
            end
            else
            begin : g_zero
                assign pad[j] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            bub_grp_next[g]  = '0;
            post_grp_next[g] = '0;
            hyb_grp_next[g]  = '0;
            tr_grp_next[g]   = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                bub_grp_next[g]  = bub_grp_next[g]  + ACC_W'($signed(pad[g*GROUP+k].bub));
                post_grp_next[g] = post_grp_next[g] + ACC_W'($signed(pad[g*GROUP+k].post));
                hyb_grp_next[g]  = hyb_grp_next[g]  + ACC_W'($signed(pad[g*GROUP+k].hyb));
                tr_grp_next[g]   = tr_grp_next[g]   + ACC_W'($signed(pad[g*GROUP+k].tr));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            bub_grp_reg  <= bub_grp_next;
            post_grp_reg <= post_grp_next;
            hyb_grp_reg  <= hyb_grp_next;
            tr_grp_reg   <= tr_grp_next;
            side_reg     <= side;
        end
    end

    // The bubble sums enter negated: the bubble energy is the end penalties minus
    // the stacking sum, plus the scrunch offset.
    always_comb
    begin
        logic signed [ACC_W-1:0] hyb_acc;
        logic signed [ACC_W-1:0] tr_acc;
        logic signed [ACC_W-1:0] tot_acc;
        hyb_acc = $signed({{(ACC_W-CFG_W){1'b0}}, side_reg.hinit});
        tr_acc  = hyb_acc + side_reg.post_base;
        for (int g = 0; g < NGRP; g++)
        begin
            hyb_acc = hyb_acc + hyb_grp_reg[g];
            tr_acc  = tr_acc + tr_grp_reg[g] - post_grp_reg[g];
        end
        tot_acc = hyb_acc + side_reg.bub_base;
        for (int g = 0; g < NGRP; g++)
        begin
            tot_acc = tot_acc - bub_grp_reg[g];
        end
        total_next   = sat15(tot_acc);
        hybrid_next  = sat15(hyb_acc);
        shifted_next = sat15(tr_acc);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            total_reg   <= total_next;
            hybrid_reg  <= hybrid_next;
            shifted_reg <= shifted_next;
        end
    end

    assign total   = total_reg;
    assign hybrid  = hybrid_reg;
    assign shifted = shifted_reg;

endmodule

`default_nettype wire

// ===== rtl/nbh_top_placeholder_unused.sv =====
// Holds no logic of its own beyond the configuration register file of the block.
// Depends on nbh_pkg; instantiated by nn_bubble_hybrid_energy.
`default_nettype none

module nbh_cfg
    import nbh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [1:0]        wr_index,
    input  wire logic [CFG_W-1:0]  wr_data,
    output logic [CFG_W-1:0]       init_gc,
    output logic [CFG_W-1:0]       init_at,
    output logic [CFG_W-1:0]       hybrid_init,
    output logic                   sliding_mode
);

    logic [CFG_W-1:0] init_gc_reg;
    logic [CFG_W-1:0] init_at_reg;
    logic [CFG_W-1:0] hybrid_init_reg;
    logic             sliding_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_gc_reg      <= INIT_GC_RESET;
            init_at_reg      <= INIT_AT_RESET;
            hybrid_init_reg  <= HYBRID_INIT_RESET;
            sliding_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_INIT_GC:      init_gc_reg      <= wr_data;
                REG_INIT_AT:      init_at_reg      <= wr_data;
                REG_HYBRID_INIT:  hybrid_init_reg  <= wr_data;
                REG_SLIDING_MODE: sliding_mode_reg <= wr_data[0];
                default:          ;
            endcase
        end
    end

    assign init_gc      = init_gc_reg;
    assign init_at      = init_at_reg;
    assign hybrid_init  = hybrid_init_reg;
    assign sliding_mode = sliding_mode_reg;

endmodule

`default_nettype wire

// ===== rtl/nn_bubble_hybrid_energy.sv =====
// Nearest-neighbor free energy of a transcription bubble and its RNA/DNA hybrid.
// Each beat carries a window of up to 23 bases and a scrunch count; one result beat
// follows with the total, hybrid and translocated energies in hundredths of a kcal/mol.
// The block is a three-stage pipeline (lane lookup, group sums, final merge), each
// stage registered, so it takes one window per cycle; only a stalled result slows
// the input. Configuration must be written only while idle; the block itself does
// not enforce it.
`default_nettype none

module nn_bubble_hybrid_energy
    import nbh_pkg::*;
#(
    parameter int MAX_SCRUNCH = 9
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [1:0]               wr_index,
    input  wire logic [CFG_W-1:0]         wr_data,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic [WINDOW_W-1:0]      bases_window,
    input  wire logic [SCRUNCH_W-1:0]     scrunch_count,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed [OUT_W-1:0]       total_energy,
    output logic signed [OUT_W-1:0]       hybrid_sum,
    output logic signed [OUT_W-1:0]       shifted_energy
);

    localparam int NLANE = 12 + MAX_SCRUNCH;
    localparam int NBASE = NLANE + 2;
    localparam int IDX_W = $clog2(NBASE);

    logic [CFG_W-1:0] init_gc;
    logic [CFG_W-1:0] init_at;
    logic [CFG_W-1:0] hybrid_init;
    logic             sliding_mode;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic ready1;
    logic ready2;
    logic ready3;
    logic en1;
    logic en2;
    logic en3;

    logic [BASE_W-1:0]    seq [NBASE];
    logic [SCRUNCH_W-1:0] s_c;
    logic [LAST_W-1:0]    last_pos;
    logic [LAST_W-1:0]    last_next_pos;
    lane_ctl_t            ctl;
    side_t                side_reg;
    side_t                side_next;
    lane_terms_t          terms [NLANE];

    nbh_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .init_gc      (init_gc),
        .init_at      (init_at),
        .hybrid_init  (hybrid_init),
        .sliding_mode (sliding_mode)
    );

    // Each stage may load when it is empty or the stage after it moves on.
    assign ready3     = !v3_reg || !result_stall;
    assign ready2     = !v2_reg || ready3;
    assign ready1     = !v1_reg || ready2;
    assign item_stall = !ready1;
    assign en1        = ready1 && item_valid;
    assign en2        = ready2 && v1_reg;
    assign en3        = ready3 && v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= item_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Bases past the ones the field carries read as A.
    genvar k;
    generate
        for (k = 0; k < NBASE; k++)
        begin : g_seq
            if (k < BASES_CARRIED)
            begin : g_carried
                assign seq[k] = bases_window[BASE_W*k +: BASE_W];
            end
            else
            begin : g_beyond
                assign seq[k] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        s_c = (scrunch_count > SCRUNCH_W'(MAX_SCRUNCH)) ? SCRUNCH_W'(MAX_SCRUNCH)
                                                        : scrunch_count;
        ctl.s_zero   = (s_c == '0);
        ctl.s_one    = (s_c == SCRUNCH_W'(1));
        ctl.slide    = sliding_mode;
        ctl.full_pre = !ctl.s_zero || !sliding_mode;
        last_pos     = ctl.s_zero ? LAST_UNSCRUNCHED : (LAST_W'(s_c) + LAST_OFFSET);
        last_next_pos = last_pos + LAST_W'(1);
        ctl.last     = last_pos;

        side_next.hinit = hybrid_init;
        side_next.bub_base =
            $signed(ACC_W'(end_pen(seq[0], init_gc, init_at)))
            + $signed(ACC_W'(end_pen(seq[last_pos[IDX_W-1:0]], init_gc, init_at)))
            + $signed(ACC_W'(s_c) * SCRUNCH_STEP);
        side_next.post_base =
            $signed(ACC_W'(end_pen(ctl.full_pre ? seq[0] : seq[1], init_gc, init_at)))
            + $signed(ACC_W'(end_pen(seq[last_next_pos[IDX_W-1:0]], init_gc, init_at)))
            + (ctl.s_zero ? '0 : $signed(ACC_W'(s_c + SCRUNCH_W'(1)) * SCRUNCH_STEP));
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            side_reg <= side_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < NLANE; j++)
        begin : g_lane
            nbh_lane #(
                .LANE_POS (j + 1)
            ) u_lane (
                .clk   (clk),
                .en    (en1),
                .pair  ({seq[j+1], seq[j+2]}),
                .ctl   (ctl),
                .terms (terms[j])
            );
        end
    endgenerate

    nbh_merge #(
        .NLANE (NLANE)
    ) u_merge (
        .clk     (clk),
        .en2     (en2),
        .en3     (en3),
        .terms   (terms),
        .side    (side_reg),
        .total   (total_energy),
        .hybrid  (hybrid_sum),
        .shifted (shifted_energy)
    );

    assign result_valid = v3_reg;

endmodule

`default_nettype wire

// ===== tb/tb_nn_bubble_hybrid_energy.sv =====
// Self-checking testbench for nn_bubble_hybrid_energy: windows go in, three energies come out.
// Results are predicted from the nearest-neighbor tables below and checked in order.
// Depends on nbh_pkg for port widths and register indexes.
`timescale 1ns / 100ps

module tb_nn_bubble_hybrid_energy
    import nbh_pkg::*;
();

    localparam int MAX_SCRUNCH = 9;
    localparam int DRAIN_CYCLES = 10;
    localparam int JAM_CYCLES = 80;
    localparam int DRAIN_GUARD = 50000;

    typedef struct packed {
        logic [WINDOW_W-1:0]  window;
        logic [SCRUNCH_W-1:0] scrunch;
    } window_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] total;
        logic signed [OUT_W-1:0] hybrid;
        logic signed [OUT_W-1:0] shifted;
    } energy_t;

    // DNA/DNA and RNA/DNA stacking energies, indexed by 4*upstream + downstream base.
    int dna_stack [16] = '{
        -100, -144, -128,  -88,
        -145, -184, -217, -128,
        -130, -224, -184, -144,
         -58, -130, -145, -100
    };
    int rna_stack [16] = '{
        -100, -210, -180,  -90,
         -90, -210, -170,  -90,
        -130, -270, -290, -110,
         -60, -150, -160,  -20
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     wr_en = 1'b0;
    logic [1:0]               wr_index = 2'd0;
    logic [CFG_W-1:0]         wr_data = '0;
    logic                     item_valid = 1'b0;
    logic                     item_stall;
    logic [WINDOW_W-1:0]      bases_window = '0;
    logic [SCRUNCH_W-1:0]     scrunch_count = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [OUT_W-1:0]  total_energy;
    logic signed [OUT_W-1:0]  hybrid_sum;
    logic signed [OUT_W-1:0]  shifted_energy;

    // Shadow copy of the configuration registers.
    int cfg_gc = 98;
    int cfg_at = 103;
    int cfg_hinit = 310;
    bit cfg_slide = 1'b0;

    window_item_t window_queue [$];
    energy_t      energy_due [$];

    int  errors = 0;
    int  windows_in = 0;
    int  results_seen = 0;
    int  setting_count = 1;
    bit  quiet = 1'b0;
    bit  item_taken = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  jam_req = 0;
    int  jam_seen = 0;

    nn_bubble_hybrid_energy #(
        .MAX_SCRUNCH(MAX_SCRUNCH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .bases_window(bases_window),
        .scrunch_count(scrunch_count),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .total_energy(total_energy),
        .hybrid_sum(hybrid_sum),
        .shifted_energy(shifted_energy)
    );

    always #2 clk = ~clk;

    function automatic int end_penalty(int b);
        return (b == int'(BASE_C) || b == int'(BASE_G)) ? cfg_gc : cfg_at;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp15(int v);
        int c;
        c = v;
        if (c > 16383)
        begin
            c = 16383;
        end
        else if (c < -16384)
        begin
            c = -16384;
        end
        return c[OUT_W-1:0];
    endfunction

    function automatic energy_t predict_energy(logic [WINDOW_W-1:0] win,
                                               logic [SCRUNCH_W-1:0] scr);
        int      s;
        int      last;
        int      start;
        int      bub;
        int      post;
        int      hyb;
        int      tr;
        int      pair;
        int      b [24];
        bit      full_pre;
        energy_t e;
        s = (int'(scr) > MAX_SCRUNCH) ? MAX_SCRUNCH : int'(scr);
        last = (s != 0) ? 12 + s : 13;
        for (int k = 0; k < 23; k++)
        begin
            b[k] = int'(win[2*k +: 2]);
        end
        b[23] = 0;
        // The unscrunched sliding bubble drops its first base after translocation.
        full_pre = (s != 0) || !cfg_slide;
        bub = -end_penalty(b[0]) - end_penalty(b[last]);
        post = -(full_pre ? end_penalty(b[0]) : end_penalty(b[1])) - end_penalty(b[last + 1]);
        hyb = cfg_hinit;
        tr = hyb;
        start = (s != 0) ? 11 : 3;
        for (int i = 1; i + 1 <= last; i++)
        begin
            pair = b[i] * 4 + b[i + 1];
            bub += dna_stack[pair];
            if (full_pre || i >= 2)
            begin
                post += dna_stack[pair];
            end
            if (i >= start && i + 1 < last && s != 1)
            begin
                hyb += rna_stack[pair];
                if (i > 3 || !cfg_slide)
                begin
                    tr += rna_stack[pair];
                end
            end
        end
        post += dna_stack[b[last] * 4 + b[last + 1]];
        bub = -bub + 100 * s;
        post = -post + ((s > 0) ? 100 * (s + 1) : 0);
        e.total = clamp15(hyb + bub);
        e.hybrid = clamp15(hyb);
        e.shifted = clamp15(tr + post);
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Output side: check each result beat, then record any window beat taken this edge.
    always @(posedge clk)
    begin : monitor
        energy_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (energy_due.size() == 0)
            begin
                report_mismatch("unexpected result beat, total", int'(total_energy), 0);
            end
            else
            begin
                want = energy_due.pop_front();
                if (total_energy !== want.total)
                begin
                    report_mismatch("total_energy", int'(total_energy), int'(want.total));
                end
                if (hybrid_sum !== want.hybrid)
                begin
                    report_mismatch("hybrid_sum", int'(hybrid_sum), int'(want.hybrid));
                end
                if (shifted_energy !== want.shifted)
                begin
                    report_mismatch("shifted_energy", int'(shifted_energy),
                                    int'(want.shifted));
                end
            end
        end
        if (rst_n && item_valid && !item_stall)
        begin
            energy_due.push_back(predict_energy(bases_window, scrunch_count));
            windows_in++;
        end
        item_taken <= rst_n && item_valid && !item_stall;
    end

    // Input side: present the next window once the current beat is gone.
    always @(negedge clk)
    begin : driver
        window_item_t nxt;
        if (!item_valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (rst_n && window_queue.size() != 0)
            begin
                nxt = window_queue.pop_front();
                item_valid <= 1'b1;
                bases_window <= nxt.window;
                scrunch_count <= nxt.scrunch;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    gap_left <= $urandom_range(1, 17);
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: random bursts, plus a long jam on request.
    always @(negedge clk)
    begin
        if (jam_seen != jam_req)
        begin
            jam_seen <= jam_req;
            stall_left <= JAM_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_INIT_GC:      cfg_gc = int'(data);
            REG_INIT_AT:      cfg_at = int'(data);
            REG_HYBRID_INIT:  cfg_hinit = int'(data);
            REG_SLIDING_MODE: cfg_slide = data[0];
            default:          ;
        endcase
    endtask

    task automatic set_config(int gc, int at, int hinit, bit slide);
        logic [CFG_W-1:0] mode_word;
        // Upper bits of the mode word are junk; only bit 0 must stick.
        mode_word = CFG_W'($urandom);
        mode_word[0] = slide;
        write_reg(REG_INIT_GC, CFG_W'(gc));
        write_reg(REG_INIT_AT, CFG_W'(at));
        write_reg(REG_HYBRID_INIT, CFG_W'(hinit));
        write_reg(REG_SLIDING_MODE, mode_word);
        setting_count++;
    endtask

    task automatic push_window(logic [WINDOW_W-1:0] win, logic [SCRUNCH_W-1:0] scr);
        window_item_t it;
        it.window = win;
        it.scrunch = scr;
        window_queue.push_back(it);
    endtask

    task automatic push_random_windows(int n);
        logic [WINDOW_W-1:0]  win;
        logic [SCRUNCH_W-1:0] scr;
        for (int i = 0; i < n; i++)
        begin
            win = WINDOW_W'({$urandom, $urandom});
            // Mostly legal scrunch counts, some above the clamp.
            if ($urandom_range(0, 3) == 0)
            begin
                scr = SCRUNCH_W'($urandom_range(MAX_SCRUNCH + 1, 15));
            end
            else
            begin
                scr = SCRUNCH_W'($urandom_range(0, MAX_SCRUNCH));
            end
            push_window(win, scr);
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((window_queue.size() != 0 || item_valid || energy_due.size() != 0)
               && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic jam_after(int count);
        int target;
        target = windows_in + count;
        while (windows_in < target && (window_queue.size() != 0 || item_valid))
        begin
            @(negedge clk);
        end
        jam_req++;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed windows under the reset configuration.
        push_window('0, 4'd0);
        push_window({WINDOW_W{1'b1}}, 4'd0);
        push_window({23{BASE_C}}, 4'd0);
        push_window({23{BASE_G}}, 4'd9);
        push_window('0, 4'd1);
        push_window({WINDOW_W{1'b1}}, 4'd1);
        push_window({WINDOW_W{1'b1}}, 4'd9);
        push_window({WINDOW_W{1'b1}}, 4'd15);
        push_window('0, 4'd15);
        for (int s = 0; s < 16; s++)
        begin
            push_window(WINDOW_W'({$urandom, $urandom}), SCRUNCH_W'(s));
        end
        wait_idle();

        set_config(0, 0, 0, 1'b0);
        push_random_windows(250);
        wait_idle();

        set_config(1023, 1023, 1023, 1'b1);
        push_random_windows(250);
        wait_idle();

        // Long result jam while windows keep coming, so the pipeline backs up.
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 1'b1);
        push_random_windows(300);
        jam_after(10);
        wait_idle();

        set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 1'b0);
        push_random_windows(300);
        jam_after(150);
        wait_idle();

        set_config(98, 103, 310, 1'b1);
        push_random_windows(300);
        wait_idle();

        // Final stretch at full rate on both sides.
        quiet = 1'b1;
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
        push_random_windows(300);
        wait_idle();

        if (energy_due.size() != 0)
        begin
            report_mismatch("results never delivered", 0, energy_due.size());
        end
        $display("Checked %0d energy results from %0d windows across %0d register settings.",
                 results_seen, windows_in, setting_count);
        $display("Scrunch counts 0 to 15, both bubble models and long output jams were covered.");
        if (errors == 0)
        begin
            $display("nn_bubble_hybrid_energy verification clean");
        end
        else
        begin
            $display("nn_bubble_hybrid_energy verification failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results still expected.", energy_due.size());
        $display("nn_bubble_hybrid_energy verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nbh_pkg.sv
rtl/nbh_lane.sv
rtl/nbh_merge.sv
rtl/nbh_top_placeholder_unused.sv
rtl/nn_bubble_hybrid_energy.sv
tb/tb_nn_bubble_hybrid_energy.sv
